[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the core RTL. They compile to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/core/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph box segmenter package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int IMG_WIDTH_W  = 9;
	localparam int IMG_HEIGHT_W = 5;

	localparam int BOX_X_W      = 8;
	localparam int BOX_Y_W      = 4;
	localparam int BOX_WIDTH_W  = 9;
	localparam int BOX_HEIGHT_W = 5;

	localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 9'd256;
	localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 5'd15;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_FIND = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} seg_state_t;

endpackage

[rtl/core/glyph_box_segmenter.sv]
// ----------------------------------------------------------------------------
// Glyph box segmenter
// Loads a binary text-line image and returns character boxes one find at a time.
// ----------------------------------------------------------------------------
// Usage: each input word is either a pixel load or a find request. Loads carry
// one pixel in row-major order; frame_start on a load restarts the write
// position and the column cursor. A load returns nothing.
// A find returns exactly one output word: found with the box of the next run
// of inked columns from the cursor, or found low with a zero box.
// A find scans columns from the cursor and reads every row of each column, one
// pixel per cycle from the read port of the pixel memory; the default image
// is 256 by 15 pixels. A find with the cursor at or past the width scans
// no column and returns found low with a zero box.
// The configuration channel is always ready; it is to be written only while
// idle, a rule on the user that the block itself does not enforce.
// An output register holds the finished word, so a load can be accepted while
// the receiver stalls; a second find waits at its end until the register
// frees. Reset clears the cursor, the write position, the handshakes and the
// registers to their defaults; the pixel memory is not cleared and holds
// unknown data until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glyph_box_segmenter #(
	parameter int MAX_WIDTH  = gbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gbs_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [gbs_pkg::CFG_DATA_W-1:0]        cfg_data,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  kind,
	input  logic                                  pixel,
	input  logic                                  frame_start,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  found,
	output logic [gbs_pkg::BOX_X_W-1:0]           box_x,
	output logic [gbs_pkg::BOX_Y_W-1:0]           box_y,
	output logic [gbs_pkg::BOX_WIDTH_W-1:0]       box_width,
	output logic [gbs_pkg::BOX_HEIGHT_W-1:0]      box_height
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	gbs_pkg::seg_state_t state_q, state_d;

	logic [gbs_pkg::IMG_WIDTH_W-1:0]  image_width_q;
	logic [gbs_pkg::IMG_HEIGHT_W-1:0] image_height_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic [AW-1:0] wr_pos_q;
	logic [WW-1:0] cursor_q;

	logic          in_fire;
	logic          load_fire;
	logic          find_fire;
	logic          find_empty;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_rdata;

	logic          iss_active_q;
	logic [WW-1:0] iss_col_q;
	logic [RW-1:0] iss_row_q;
	logic [AW-1:0] iss_addr_q;
	logic          iss_last;
	logic          iss_fire;

	logic          valid_s1;
	logic          last_s1;
	logic [WW-1:0] col_s1;
	logic [RW-1:0] row_s1;

	logic          col_ink_q;
	logic [RW-1:0] col_top_q;
	logic [RW-1:0] col_bot_q;

	logic          in_run_q;
	logic [WW-1:0] run_x_q;
	logic [WW-1:0] run_len_q;
	logic [RW-1:0] run_top_q;
	logic [RW-1:0] run_bot_q;

	logic          col_done;
	logic          cink;
	logic [RW-1:0] ctop;
	logic [RW-1:0] cbot;
	logic          nxt_in_run;
	logic [WW-1:0] nxt_x;
	logic [WW-1:0] nxt_len;
	logic [RW-1:0] nxt_top;
	logic [RW-1:0] nxt_bot;
	logic          scan_end;

	logic          res_found_q;
	logic [WW-1:0] res_x_q;
	logic [RW-1:0] res_top_q;
	logic [WW-1:0] res_len_q;
	logic [HW-1:0] res_hgt_q;

	logic          out_load;
	logic          done_wait;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= gbs_pkg::IMG_WIDTH_RST;
			image_height_q <= gbs_pkg::IMG_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gbs_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[gbs_pkg::IMG_WIDTH_W-1:0];
				end
				gbs_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[gbs_pkg::IMG_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbs_pkg::ST_IDLE: begin
				if (find_fire) begin
					state_d = find_empty ? gbs_pkg::ST_DONE : gbs_pkg::ST_SCAN;
				end
			end
			gbs_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = gbs_pkg::ST_DONE;
				end
			end
			gbs_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = gbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		done_wait = 1'b0;
		unique case (state_q)
			gbs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			gbs_pkg::ST_SCAN: begin
			end
			gbs_pkg::ST_DONE: begin
				done_wait = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign in_fire    = in_valid && in_ready;
	assign load_fire  = in_fire && (kind == gbs_pkg::KIND_LOAD);
	assign find_fire  = in_fire && (kind == gbs_pkg::KIND_FIND);
	assign find_empty = (cursor_q >= w_eff);
	assign out_load   = done_wait && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ram_we    = load_fire;
	assign ram_waddr = frame_start ? '0 : wr_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			cursor_q <= '0;
		end else begin
			if (load_fire) begin
				if (32'(ram_waddr) == STORE_DEPTH - 1) begin
					wr_pos_q <= '0;
				end else begin
					wr_pos_q <= ram_waddr + AW'(1);
				end
				if (frame_start) begin
					cursor_q <= '0;
				end
			end
			if (scan_end && nxt_in_run) begin
				cursor_q <= nxt_x + nxt_len;
			end
		end
	end

	gbs_ram #(
		.WIDTH(1),
		.DEPTH(STORE_DEPTH)
	) u_pixel_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(pixel),
		.raddr(iss_addr_q),
		.rdata(ram_rdata)
	);

	assign iss_last = (HW'(iss_row_q) == h_eff - HW'(1));
	assign iss_fire = (state_q == gbs_pkg::ST_SCAN) && iss_active_q && !scan_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_active_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= iss_fire;
			if (find_fire) begin
				iss_active_q <= !find_empty;
			end else if (scan_end) begin
				iss_active_q <= 1'b0;
			end else if (iss_fire && iss_last && (iss_col_q == w_eff - WW'(1))) begin
				iss_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (find_fire) begin
			iss_col_q  <= cursor_q;
			iss_row_q  <= '0;
			iss_addr_q <= AW'(cursor_q);
		end else if (iss_fire) begin
			if (iss_last) begin
				iss_col_q  <= iss_col_q + WW'(1);
				iss_row_q  <= '0;
				iss_addr_q <= AW'(iss_col_q + WW'(1));
			end else begin
				iss_row_q  <= iss_row_q + RW'(1);
				iss_addr_q <= iss_addr_q + AW'(w_eff);
			end
		end
		last_s1 <= iss_last;
		col_s1  <= iss_col_q;
		row_s1  <= iss_row_q;
	end

	assign col_done = (state_q == gbs_pkg::ST_SCAN) && valid_s1 && last_s1;
	assign cink     = col_ink_q || ram_rdata;
	assign ctop     = col_ink_q ? col_top_q : row_s1;
	assign cbot     = ram_rdata ? row_s1 : col_bot_q;

	always_comb begin
		nxt_in_run = in_run_q || cink;
		nxt_x      = in_run_q ? run_x_q : col_s1;
		if (!cink) begin
			nxt_len = run_len_q;
			nxt_top = run_top_q;
			nxt_bot = run_bot_q;
		end else if (in_run_q) begin
			nxt_len = run_len_q + WW'(1);
			nxt_top = (run_top_q < ctop) ? run_top_q : ctop;
			nxt_bot = (run_bot_q > cbot) ? run_bot_q : cbot;
		end else begin
			nxt_len = WW'(1);
			nxt_top = ctop;
			nxt_bot = cbot;
		end
	end

	assign scan_end = col_done && ((!cink && in_run_q) || (col_s1 == w_eff - WW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_ink_q <= 1'b0;
			in_run_q  <= 1'b0;
		end else if (find_fire) begin
			col_ink_q <= 1'b0;
			in_run_q  <= 1'b0;
		end else if ((state_q == gbs_pkg::ST_SCAN) && valid_s1) begin
			if (last_s1) begin
				col_ink_q <= 1'b0;
				in_run_q  <= nxt_in_run;
			end else if (ram_rdata) begin
				col_ink_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == gbs_pkg::ST_SCAN) && valid_s1 && !last_s1 && ram_rdata) begin
			if (!col_ink_q) begin
				col_top_q <= row_s1;
			end
			col_bot_q <= row_s1;
		end
		if (col_done) begin
			run_x_q   <= nxt_x;
			run_len_q <= nxt_len;
			run_top_q <= nxt_top;
			run_bot_q <= nxt_bot;
		end
		if (find_fire && find_empty) begin
			res_found_q <= 1'b0;
			res_x_q     <= '0;
			res_top_q   <= '0;
			res_len_q   <= '0;
			res_hgt_q   <= '0;
		end else if (scan_end) begin
			res_found_q <= nxt_in_run;
			res_x_q     <= nxt_in_run ? nxt_x : '0;
			res_top_q   <= nxt_in_run ? nxt_top : '0;
			res_len_q   <= nxt_in_run ? nxt_len : '0;
			res_hgt_q   <= nxt_in_run ? (HW'(nxt_bot) - HW'(nxt_top) + HW'(1)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found      <= res_found_q;
			box_x      <= gbs_pkg::BOX_X_W'(res_x_q);
			box_y      <= gbs_pkg::BOX_Y_W'(res_top_q);
			box_width  <= gbs_pkg::BOX_WIDTH_W'(res_len_q);
			box_height <= gbs_pkg::BOX_HEIGHT_W'(res_hgt_q);
		end
	end

	`ASSERT_PROP(a_issue_in_width, clk, arst_n, (state_q == gbs_pkg::ST_SCAN && iss_active_q) |-> (iss_col_q < w_eff), "column issued past the image width")

	`ASSERT_PROP(a_run_in_width, clk, arst_n, (state_q == gbs_pkg::ST_SCAN && in_run_q) |-> ((WW + 1)'(run_x_q) + (WW + 1)'(run_len_q) <= (WW + 1)'(w_eff)), "column run extends past the image width")

	`ASSERT_PROP(a_found_box_sane, clk, arst_n, (state_q == gbs_pkg::ST_DONE && res_found_q) |-> (res_len_q != '0 && res_hgt_q != '0), "found box has an empty extent")

	`ASSERT_NEVER(a_no_write_in_scan, clk, arst_n, ram_we && state_q != gbs_pkg::ST_IDLE, "pixel memory written outside idle")

endmodule

[rtl/core/gbs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
